/* rtl/scs1_pkg.sv */
// Shared types, constants and code tables for the scancode set 1 decoder.
package scs1_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] SC_RELEASE_BIT = 8'h80;
    localparam logic [7:0] SC_CODE_MASK   = 8'h7F;
    localparam logic [7:0] SC_PREFIX_E0   = 8'hE0;
    localparam logic [7:0] SC_PREFIX_E1   = 8'hE1;
    localparam logic [7:0] SC_FAKE_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_FAKE_RSHIFT = 8'h36;
    localparam logic [7:0] SC_PAUSE_FIRST = 8'h1D;
    localparam logic [7:0] SC_PAUSE_LAST  = 8'h45;

    localparam logic [6:0] KEY_NONE    = 7'd0;
    localparam logic [6:0] KEY_LBRACE  = 7'd8;
    localparam logic [6:0] KEY_LBRACK  = 7'd9;
    localparam logic [6:0] KEY_RBRACK  = 7'd10;
    localparam logic [6:0] KEY_RBRACE  = 7'd11;
    localparam logic [6:0] KEY_LSHIFT  = 7'd42;
    localparam logic [6:0] KEY_RSHIFT  = 7'd54;
    localparam logic [6:0] KEY_ALTGR   = 7'd100;
    localparam logic [6:0] KEY_PAUSE   = 7'd119;

    localparam logic [2:0] TOK_LOWER    = 3'd0;
    localparam logic [2:0] TOK_UPPER    = 3'd1;
    localparam logic [2:0] TOK_LBRACKET = 3'd2;
    localparam logic [2:0] TOK_RBRACKET = 3'd3;
    localparam logic [2:0] TOK_LBRACE   = 3'd4;
    localparam logic [2:0] TOK_RBRACE   = 3'd5;

    typedef struct packed {
        logic [6:0] key;
        logic       rel;
    } scs1_evt_t;

    function automatic logic [6:0] plain_key(input logic [6:0] code);
        logic [6:0] key;
        case (code) inside
            [7'd1:7'd82]: key = code;
            7'd83:        key = 7'd84;
            [7'd86:7'd88]: key = code;
            default:      key = KEY_NONE;
        endcase
        return key;
    endfunction

    function automatic logic [6:0] ext_key(input logic [7:0] code);
        logic [6:0] key;
        case (code)
            8'd29:   key = 7'd97;
            8'd56:   key = 7'd100;
            8'd71:   key = 7'd102;
            8'd72:   key = 7'd103;
            8'd73:   key = 7'd104;
            8'd75:   key = 7'd105;
            8'd77:   key = 7'd106;
            8'd79:   key = 7'd107;
            8'd80:   key = 7'd108;
            8'd81:   key = 7'd109;
            8'd82:   key = 7'd110;
            8'd83:   key = 7'd111;
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

/* rtl/scs1_front.sv */
// Front end: prefix tracking, release detection and keycode lookup per byte.
module scs1_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_take,
    input  logic [7:0]           scan_byte,
    output logic                 evt_push,
    output scs1_pkg::scs1_evt_t  evt
);

    typedef enum logic [1:0] {
        E1_IDLE,
        E1_SEEN,
        E1_FIRST
    } e1_stage_t;

    logic       e0_reg, e0_next;
    e1_stage_t  e1_stage_reg, e1_stage_next;
    logic [7:0] e1_first_reg, e1_first_next;

    logic       e1_busy;
    logic       strip;
    logic [7:0] code;
    logic [6:0] key;

    assign e1_busy = (e1_stage_reg == E1_SEEN) || (e1_stage_reg == E1_FIRST);
    assign strip   = ((scan_byte & scs1_pkg::SC_RELEASE_BIT) != 8'h00)
                  && (e1_busy || scan_byte != scs1_pkg::SC_PREFIX_E1)
                  && (e0_reg || scan_byte != scs1_pkg::SC_PREFIX_E0);
    assign code    = strip ? (scan_byte & scs1_pkg::SC_CODE_MASK) : scan_byte;

    always_comb begin
        e0_next       = e0_reg;
        e1_stage_next = e1_stage_reg;
        e1_first_next = e1_first_reg;
        key           = scs1_pkg::KEY_NONE;
        if (e0_reg) begin
            if (code != scs1_pkg::SC_FAKE_LSHIFT && code != scs1_pkg::SC_FAKE_RSHIFT) begin
                key = scs1_pkg::ext_key(code);
            end
            e0_next = 1'b0;
        end else begin
            case (e1_stage_reg)
                E1_FIRST: begin
                    if (e1_first_reg == scs1_pkg::SC_PAUSE_FIRST
                        && code == scs1_pkg::SC_PAUSE_LAST) begin
                        key = scs1_pkg::KEY_PAUSE;
                    end
                    e1_stage_next = E1_IDLE;
                end
                E1_SEEN: begin
                    e1_first_next = code;
                    e1_stage_next = E1_FIRST;
                end
                default: begin
                    if (code == scs1_pkg::SC_PREFIX_E0) begin
                        e0_next = 1'b1;
                    end else if (code == scs1_pkg::SC_PREFIX_E1) begin
                        e1_stage_next = E1_SEEN;
                    end else if (code[7] == 1'b0) begin
                        key = scs1_pkg::plain_key(code[6:0]);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e0_reg       <= 1'b0;
            e1_stage_reg <= E1_IDLE;
            e1_first_reg <= 8'h00;
        end else if (byte_take) begin
            e0_reg       <= e0_next;
            e1_stage_reg <= e1_stage_next;
            e1_first_reg <= e1_first_next;
        end
    end

    assign evt_push = byte_take && (key != scs1_pkg::KEY_NONE);
    assign evt.key  = key;
    assign evt.rel  = strip;

endmodule

/* rtl/scs1_queue.sv */
// Small event queue between the front and back ends.
module scs1_queue #(
    parameter int unsigned DEPTH = scs1_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  scs1_pkg::scs1_evt_t  push_evt,
    input  logic                 pop,
    output scs1_pkg::scs1_evt_t  head_evt,
    output logic                 empty,
    output logic                 full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    scs1_pkg::scs1_evt_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_evt = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

/* rtl/scs1_back.sv */
// Back end: held-key map, token class and the output register.
module scs1_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scs1_pkg::scs1_evt_t  head_evt,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_key_number,
    output logic                 m_is_release,
    output logic [2:0]           m_token_class
);

    logic [127:0] held_reg;
    logic         valid_reg;
    logic [6:0]   key_reg;
    logic         rel_reg;
    logic [2:0]   cls_reg, cls_next;

    assign q_pop = !q_empty && (!valid_reg || m_ready);

    always_comb begin
        cls_next = scs1_pkg::TOK_LOWER;
        if (held_reg[scs1_pkg::KEY_LSHIFT] || held_reg[scs1_pkg::KEY_RSHIFT]) begin
            cls_next = scs1_pkg::TOK_UPPER;
        end else if (held_reg[scs1_pkg::KEY_ALTGR]) begin
            case (head_evt.key)
                scs1_pkg::KEY_LBRACK: cls_next = scs1_pkg::TOK_LBRACKET;
                scs1_pkg::KEY_RBRACK: cls_next = scs1_pkg::TOK_RBRACKET;
                scs1_pkg::KEY_LBRACE: cls_next = scs1_pkg::TOK_LBRACE;
                scs1_pkg::KEY_RBRACE: cls_next = scs1_pkg::TOK_RBRACE;
                default:              cls_next = scs1_pkg::TOK_LOWER;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                held_reg[head_evt.key] <= !head_evt.rel;
                valid_reg              <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            key_reg <= head_evt.key;
            rel_reg <= head_evt.rel;
            cls_reg <= cls_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_key_number  = key_reg;
    assign m_is_release  = rel_reg;
    assign m_token_class = cls_reg;

endmodule

/* rtl/scancode_set1_decoder.sv */
// Scancode set 1 decoder top level: front end, event queue and back end.
//
// Input channel s_*: one scancode byte per beat (s_scan_byte). Bytes that
// only advance a prefix sequence, fake-shift bytes after E0 and unmapped
// codes produce no result beat.
// Output channel m_*: one beat per key event with m_key_number,
// m_is_release and m_token_class.
// Throughput: one byte per cycle, sustained while m_ready stays high.
// A result beat is written into the event queue by the edge that takes its
// last byte, then loaded from the queue head into the output register.
// s_ready falls only when the QUEUE_DEPTH-entry event queue is full, which
// happens after the receiver holds m_ready low; bytes keep flowing into the
// queue while one finished result waits at the output.
// Reset (aresetn low at a clock edge): prefix state cleared, no keys held,
// queue emptied, m_valid low. No warm-up cycles after reset.
module scancode_set1_decoder #(
    parameter int unsigned QUEUE_DEPTH = scs1_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_key_number,
    output logic       m_is_release,
    output logic [2:0] m_token_class
);

    logic                q_full, q_empty, q_pop, evt_push, byte_take;
    scs1_pkg::scs1_evt_t push_evt, head_evt;

    assign s_ready   = !q_full;
    assign byte_take = s_valid && s_ready;

    scs1_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_take (byte_take),
        .scan_byte (s_scan_byte),
        .evt_push  (evt_push),
        .evt       (push_evt)
    );

    scs1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (evt_push),
        .push_evt (push_evt),
        .pop      (q_pop),
        .head_evt (head_evt),
        .empty    (q_empty),
        .full     (q_full)
    );

    scs1_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_evt      (head_evt),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_number  (m_key_number),
        .m_is_release  (m_is_release),
        .m_token_class (m_token_class)
    );

`ifndef SYNTHESIS
    a_bracket_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_class != scs1_pkg::TOK_LOWER
            && m_token_class != scs1_pkg::TOK_UPPER
        |-> m_key_number >= scs1_pkg::KEY_LBRACE && m_key_number <= scs1_pkg::KEY_RBRACE)
        else $error("bracket class on a non-bracket key");

    a_key_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_key_number != scs1_pkg::KEY_NONE)
        else $error("result beat with keycode zero");

    a_reset_idle: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid && s_ready)
        else $error("outputs not idle after reset");
`endif

endmodule

/* verif/scancode_set1_checker.sv */
// Checker for the scancode set 1 decoder: predicts key events and compares result beats.
module scancode_set1_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_scan_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [6:0]  m_key_number,
    input  logic        m_is_release,
    input  logic [2:0]  m_token_class,
    output int unsigned fail_count,
    output int unsigned pending
);

    localparam logic [1:0] PAUSE_IDLE      = 2'd0;
    localparam logic [1:0] PAUSE_GOT_E1    = 2'd1;
    localparam logic [1:0] PAUSE_GOT_FIRST = 2'd2;

    typedef struct {
        logic [6:0] key;
        logic       rel;
        logic [2:0] cls;
    } key_event_t;

    key_event_t   expected_keys[$];
    logic         ext_pending;
    logic [1:0]   pause_stage;
    logic [7:0]   pause_first;
    logic [127:0] held_keys;

    function automatic logic [6:0] plain_keycode(input logic [7:0] code);
        if (code >= 8'd1 && code <= 8'd82) begin
            return code[6:0];
        end
        if (code == 8'd83) begin
            return 7'd84;
        end
        if (code >= 8'd86 && code <= 8'd88) begin
            return code[6:0];
        end
        return scs1_pkg::KEY_NONE;
    endfunction

    function automatic logic [6:0] ext_keycode(input logic [7:0] code);
        case (code)
            8'h1D: return 7'd97;
            8'h38: return scs1_pkg::KEY_ALTGR;
            8'h47: return 7'd102;
            8'h48: return 7'd103;
            8'h49: return 7'd104;
            8'h4B: return 7'd105;
            8'h4D: return 7'd106;
            8'h4F: return 7'd107;
            8'h50: return 7'd108;
            8'h51: return 7'd109;
            8'h52: return 7'd110;
            8'h53: return 7'd111;
            default: return scs1_pkg::KEY_NONE;
        endcase
    endfunction

    task automatic decode_byte(input logic [7:0] raw);
        logic [7:0] code;
        logic       rel;
        logic [6:0] key;
        logic [2:0] cls;
        key_event_t ev;
        code = raw;
        rel  = 1'b0;
        key  = scs1_pkg::KEY_NONE;
        cls  = scs1_pkg::TOK_LOWER;
        // prefix bytes that open a sequence keep their top bit
        if (code[7] && (pause_stage != PAUSE_IDLE || code != scs1_pkg::SC_PREFIX_E1)
                && (ext_pending || code != scs1_pkg::SC_PREFIX_E0)) begin
            rel  = 1'b1;
            code = code & scs1_pkg::SC_CODE_MASK;
        end
        if (ext_pending) begin
            if (code != scs1_pkg::SC_FAKE_LSHIFT && code != scs1_pkg::SC_FAKE_RSHIFT) begin
                key = ext_keycode(code);
            end
            ext_pending = 1'b0;
        end else if (pause_stage == PAUSE_GOT_FIRST) begin
            if (pause_first == scs1_pkg::SC_PAUSE_FIRST
                    && code == scs1_pkg::SC_PAUSE_LAST) begin
                key = scs1_pkg::KEY_PAUSE;
            end
            pause_stage = PAUSE_IDLE;
        end else if (pause_stage == PAUSE_GOT_E1) begin
            pause_first = code;
            pause_stage = PAUSE_GOT_FIRST;
        end else if (code == scs1_pkg::SC_PREFIX_E0) begin
            ext_pending = 1'b1;
        end else if (code == scs1_pkg::SC_PREFIX_E1) begin
            pause_stage = PAUSE_GOT_E1;
        end else begin
            key = plain_keycode(code);
        end
        if (key != scs1_pkg::KEY_NONE) begin
            if (held_keys[scs1_pkg::KEY_LSHIFT] || held_keys[scs1_pkg::KEY_RSHIFT]) begin
                cls = scs1_pkg::TOK_UPPER;
            end else if (held_keys[scs1_pkg::KEY_ALTGR]) begin
                case (key)
                    scs1_pkg::KEY_LBRACK: cls = scs1_pkg::TOK_LBRACKET;
                    scs1_pkg::KEY_RBRACK: cls = scs1_pkg::TOK_RBRACKET;
                    scs1_pkg::KEY_LBRACE: cls = scs1_pkg::TOK_LBRACE;
                    scs1_pkg::KEY_RBRACE: cls = scs1_pkg::TOK_RBRACE;
                    default:              cls = scs1_pkg::TOK_LOWER;
                endcase
            end
            held_keys[key] = !rel;
            ev.key = key;
            ev.rel = rel;
            ev.cls = cls;
            expected_keys.push_back(ev);
        end
    endtask

    always @(posedge aclk) begin
        key_event_t ev;
        if (!aresetn) begin
            ext_pending = 1'b0;
            pause_stage = PAUSE_IDLE;
            pause_first = 8'h00;
            held_keys   = '0;
            fail_count  = 0;
            expected_keys.delete();
        end else begin
            // retire the output beat before predicting, so a stray beat is never masked
            if (m_valid && m_ready) begin
                if (expected_keys.size() == 0) begin
                    $error("unexpected beat: key_number %0d is_release %0d token_class %0d",
                           m_key_number, m_is_release, m_token_class);
                    fail_count++;
                end else begin
                    ev = expected_keys.pop_front();
                    if (m_key_number !== ev.key) begin
                        $error("key_number: expected %0d, got %0d", ev.key, m_key_number);
                        fail_count++;
                    end
                    if (m_is_release !== ev.rel) begin
                        $error("is_release: expected %0d, got %0d", ev.rel, m_is_release);
                        fail_count++;
                    end
                    if (m_token_class !== ev.cls) begin
                        $error("token_class: expected %0d, got %0d", ev.cls, m_token_class);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_scan_byte);
            end
        end
        pending = expected_keys.size();
    end

endmodule

/* verif/tb_scancode_set1_decoder.sv */
// Testbench top for the scancode set 1 decoder: byte stimulus, output stalls and verdict.
module tb_scancode_set1_decoder;

    localparam int unsigned ITEM_COUNT   = 1950;
    localparam int unsigned QUIET_TAIL   = 200;
    localparam int unsigned HOLD_AT      = 400;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_scan_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [6:0] m_key_number;
    logic       m_is_release;
    logic [2:0] m_token_class;

    int unsigned fail_count;
    int unsigned pending;

    logic [7:0]  scan_stream[$];
    int unsigned total_bytes = 0;
    int unsigned sent_cnt    = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned hold_left   = 0;
    int unsigned stall_left  = 0;
    int unsigned rx_seg      = 0;
    int unsigned rx_rate     = 0;
    bit          hold_done   = 1'b0;
    logic        quiet;

    logic [7:0] ext_codes[12] = '{8'h1D, 8'h38, 8'h47, 8'h48, 8'h49, 8'h4B,
                                  8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53};
    logic [7:0] mod_codes[3]  = '{scs1_pkg::SC_FAKE_LSHIFT, scs1_pkg::SC_FAKE_RSHIFT, 8'h38};

    assign quiet = (sent_cnt + QUIET_TAIL >= total_bytes);

    always #1 aclk = ~aclk;

    scancode_set1_decoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_scan_byte   (s_scan_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_number  (m_key_number),
        .m_is_release  (m_is_release),
        .m_token_class (m_token_class)
    );

    scancode_set1_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_scan_byte   (s_scan_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_number  (m_key_number),
        .m_is_release  (m_is_release),
        .m_token_class (m_token_class),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn && s_valid && s_ready) begin
            sent_cnt <= sent_cnt + 1;
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("scancode_set1_decoder regression: fail");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold to back up the input
    always @(negedge aclk) begin
        rx_seg = rx_seg + 1;
        if (rx_seg % 150 == 0) begin
            rx_rate = $urandom_range(0, 2);
        end
        if (!hold_done && aresetn && sent_cnt >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (quiet) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (rx_rate != 0 && $urandom_range(0, rx_rate == 1 ? 7 : 2) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int unsigned i;
        int unsigned sel;
        int unsigned tx_rate;
        logic        rel;
        logic [7:0]  code;

        // directed: plain edges, shift and AltGr classes, fake shifts, Pause, odd prefixes
        scan_stream = '{8'h00, 8'h01, 8'h81, 8'h2A, 8'h1A, 8'h9A, 8'hAA, 8'h36, 8'h0B,
                        8'hB6, 8'hE0, 8'h38, 8'h09, 8'h0A, 8'h08, 8'h8B, 8'h89, 8'hE0,
                        8'hB8, 8'hE0, 8'h2A, 8'hE0, 8'hB6, 8'hE1, 8'h1D, 8'h45, 8'hE1,
                        8'h9D, 8'hC5, 8'hE1, 8'h1D, 8'h46, 8'h53, 8'h54, 8'h58, 8'h7F,
                        8'hFF, 8'hE0, 8'hE1, 8'hE0, 8'hE0, 8'hE1, 8'hE0, 8'h45};

        while (scan_stream.size() < ITEM_COUNT) begin
            sel = $urandom_range(0, 99);
            rel = 1'($urandom_range(0, 1));
            if (sel < 30) begin
                code = 8'($urandom_range(1, 88));
                scan_stream.push_back({rel, code[6:0]});
            end else if (sel < 40) begin
                code = 8'($urandom_range(8, 11));
                scan_stream.push_back({rel, code[6:0]});
            end else if (sel < 50) begin
                code = mod_codes[$urandom_range(0, 2)];
                if (code == 8'h38) begin
                    scan_stream.push_back(scs1_pkg::SC_PREFIX_E0);
                end
                scan_stream.push_back({rel, code[6:0]});
            end else if (sel < 62) begin
                code = ext_codes[$urandom_range(0, 11)];
                scan_stream.push_back(scs1_pkg::SC_PREFIX_E0);
                scan_stream.push_back({rel, code[6:0]});
            end else if (sel < 68) begin
                code = $urandom_range(0, 1) ? scs1_pkg::SC_FAKE_LSHIFT
                                            : scs1_pkg::SC_FAKE_RSHIFT;
                scan_stream.push_back(scs1_pkg::SC_PREFIX_E0);
                scan_stream.push_back({rel, code[6:0]});
            end else if (sel < 76) begin
                scan_stream.push_back(scs1_pkg::SC_PREFIX_E1);
                code = scs1_pkg::SC_PAUSE_FIRST;
                scan_stream.push_back({rel, code[6:0]});
                code = scs1_pkg::SC_PAUSE_LAST;
                scan_stream.push_back({1'($urandom_range(0, 1)), code[6:0]});
            end else if (sel < 86) begin
                scan_stream.push_back(8'($urandom_range(0, 255)));
            end else if (sel < 92) begin
                scan_stream.push_back(scs1_pkg::SC_PREFIX_E1);
                scan_stream.push_back(8'($urandom_range(0, 255)));
                scan_stream.push_back(8'($urandom_range(0, 255)));
            end else if (sel < 96) begin
                scan_stream.push_back(scs1_pkg::SC_PREFIX_E0);
                scan_stream.push_back(8'($urandom_range(0, 255)));
            end else begin
                code = $urandom_range(0, 3) == 0 ? 8'($urandom_range(84, 85))
                                                 : 8'($urandom_range(89, 127));
                scan_stream.push_back({rel, code[6:0]});
            end
        end
        total_bytes = scan_stream.size();
        tx_rate = 0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < total_bytes; i++) begin
            if (i % 100 == 0) begin
                tx_rate = $urandom_range(0, 2);
            end
            if (!quiet && tx_rate != 0 && $urandom_range(0, tx_rate == 1 ? 5 : 1) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            s_valid     <= 1'b1;
            s_scan_byte <= scan_stream[i];
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0) begin
            $display("scancode_set1_decoder regression: pass");
        end else begin
            $display("scancode_set1_decoder regression: fail");
        end
        $finish;
    end

endmodule
